// File: rtl/core/kav_pkg.sv
// Shared types, register indexes and the microprogram of the altitude/velocity filter.
`default_nettype none

package kav_pkg;

   // Default parameter values
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // Internal word width of state, covariance and scratch values
   localparam int WORD_W = 48;

   // Configuration register indexes
   localparam logic [2:0] CSR_TRANSITION_ROW0    = 3'd0;
   localparam logic [2:0] CSR_TRANSITION_ROW1    = 3'd1;
   localparam logic [2:0] CSR_CONTROL_GAIN       = 3'd2;
   localparam logic [2:0] CSR_PROCESS_NOISE_ROW0 = 3'd3;
   localparam logic [2:0] CSR_PROCESS_NOISE_ROW1 = 3'd4;
   localparam logic [2:0] CSR_OBSERVATION_ROW    = 3'd5;
   localparam logic [2:0] CSR_MEASUREMENT_NOISE  = 3'd6;

   // Operations of the shared unit and of the sequencer
   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_OUT,
      OP_CALL,
      OP_PRED
   } op_type;

   // Command from the sequencer to the arithmetic unit
   typedef struct packed {
      logic   start;
      op_type op;
   } alu_cmd_type;

   // Channel payloads
   typedef struct packed {
      logic signed [31:0] altitude_sample;
      logic signed [31:0] accel_sample;
   } req_type;

   typedef struct packed {
      logic signed [31:0] altitude_estimate;
      logic signed [31:0] velocity_estimate;
   } rsp_type;

   // Operand indexes: constants, configuration and samples
   localparam logic [5:0] R_ZERO = 6'd0;
   localparam logic [5:0] R_ONE  = 6'd1;
   localparam logic [5:0] R_GRAV = 6'd2;
   localparam logic [5:0] R_F00  = 6'd3;
   localparam logic [5:0] R_F01  = 6'd4;
   localparam logic [5:0] R_F10  = 6'd5;
   localparam logic [5:0] R_F11  = 6'd6;
   localparam logic [5:0] R_G0   = 6'd7;
   localparam logic [5:0] R_G1   = 6'd8;
   localparam logic [5:0] R_Q00  = 6'd9;
   localparam logic [5:0] R_Q01  = 6'd10;
   localparam logic [5:0] R_Q10  = 6'd11;
   localparam logic [5:0] R_Q11  = 6'd12;
   localparam logic [5:0] R_H0   = 6'd13;
   localparam logic [5:0] R_H1   = 6'd14;
   localparam logic [5:0] R_RN   = 6'd15;
   localparam logic [5:0] R_Z    = 6'd16;
   localparam logic [5:0] R_ACC  = 6'd17;

   // Scratch registers
   localparam logic [5:0] SCR_BASE = 6'd18;
   localparam int         SCR_NUM  = 26;
   localparam logic [5:0] R_X0   = 6'd18;
   localparam logic [5:0] R_X1   = 6'd19;
   localparam logic [5:0] R_P00  = 6'd20;
   localparam logic [5:0] R_P01  = 6'd21;
   localparam logic [5:0] R_P10  = 6'd22;
   localparam logic [5:0] R_P11  = 6'd23;
   localparam logic [5:0] R_U    = 6'd24;
   localparam logic [5:0] R_N0   = 6'd25;
   localparam logic [5:0] R_T0   = 6'd26;
   localparam logic [5:0] R_T1   = 6'd27;
   localparam logic [5:0] R_A00  = 6'd28;
   localparam logic [5:0] R_A01  = 6'd29;
   localparam logic [5:0] R_A10  = 6'd30;
   localparam logic [5:0] R_A11  = 6'd31;
   localparam logic [5:0] R_PH0  = 6'd32;
   localparam logic [5:0] R_PH1  = 6'd33;
   localparam logic [5:0] R_S    = 6'd34;
   localparam logic [5:0] R_K0   = 6'd35;
   localparam logic [5:0] R_K1   = 6'd36;
   localparam logic [5:0] R_INNOV = 6'd37;
   localparam logic [5:0] R_M00  = 6'd38;
   localparam logic [5:0] R_M01  = 6'd39;
   localparam logic [5:0] R_M10  = 6'd40;
   localparam logic [5:0] R_M11  = 6'd41;
   localparam logic [5:0] R_KR0  = 6'd42;
   localparam logic [5:0] R_KR1  = 6'd43;

   // One microinstruction
   typedef struct packed {
      op_type     op;
      logic [5:0] dst;
      logic [5:0] src_a;
      logic [5:0] src_b;
   } instr_type;

   // Entry points of the predict routine and of the update routine
   localparam logic [6:0] PRED_START = 7'd1;
   localparam logic [6:0] UPD_START  = 7'd41;

   function automatic instr_type mk(input op_type op, input logic [5:0] d,
                                    input logic [5:0] a, input logic [5:0] b);
      instr_type r;
      r.op    = op;
      r.dst   = d;
      r.src_a = a;
      r.src_b = b;
      return r;
   endfunction

   // Microprogram: initial control clear, predict routine, update routine
   function automatic instr_type prog(input logic [6:0] pc);
      instr_type p;
      case (pc)
         7'd0:   p = mk(OP_ADD, R_U, R_ZERO, R_ZERO);
         // Predict the state: x = F x + G u
         7'd1:   p = mk(OP_MUL, R_T0, R_F00, R_X0);
         7'd2:   p = mk(OP_MUL, R_T1, R_F01, R_X1);
         7'd3:   p = mk(OP_ADD, R_T0, R_T0, R_T1);
         7'd4:   p = mk(OP_MUL, R_T1, R_G0, R_U);
         7'd5:   p = mk(OP_ADD, R_N0, R_T0, R_T1);
         7'd6:   p = mk(OP_MUL, R_T0, R_F10, R_X0);
         7'd7:   p = mk(OP_MUL, R_T1, R_F11, R_X1);
         7'd8:   p = mk(OP_ADD, R_T0, R_T0, R_T1);
         7'd9:   p = mk(OP_MUL, R_T1, R_G1, R_U);
         7'd10:  p = mk(OP_ADD, R_X1, R_T0, R_T1);
         7'd11:  p = mk(OP_ADD, R_X0, R_N0, R_ZERO);
         // A = F P
         7'd12:  p = mk(OP_MUL, R_T0, R_F00, R_P00);
         7'd13:  p = mk(OP_MUL, R_T1, R_F01, R_P10);
         7'd14:  p = mk(OP_ADD, R_A00, R_T0, R_T1);
         7'd15:  p = mk(OP_MUL, R_T0, R_F00, R_P01);
         7'd16:  p = mk(OP_MUL, R_T1, R_F01, R_P11);
         7'd17:  p = mk(OP_ADD, R_A01, R_T0, R_T1);
         7'd18:  p = mk(OP_MUL, R_T0, R_F10, R_P00);
         7'd19:  p = mk(OP_MUL, R_T1, R_F11, R_P10);
         7'd20:  p = mk(OP_ADD, R_A10, R_T0, R_T1);
         7'd21:  p = mk(OP_MUL, R_T0, R_F10, R_P01);
         7'd22:  p = mk(OP_MUL, R_T1, R_F11, R_P11);
         7'd23:  p = mk(OP_ADD, R_A11, R_T0, R_T1);
         // P = A F^T + Q
         7'd24:  p = mk(OP_MUL, R_T0, R_A00, R_F00);
         7'd25:  p = mk(OP_MUL, R_T1, R_A01, R_F01);
         7'd26:  p = mk(OP_ADD, R_T0, R_T0, R_T1);
         7'd27:  p = mk(OP_ADD, R_P00, R_T0, R_Q00);
         7'd28:  p = mk(OP_MUL, R_T0, R_A00, R_F10);
         7'd29:  p = mk(OP_MUL, R_T1, R_A01, R_F11);
         7'd30:  p = mk(OP_ADD, R_T0, R_T0, R_T1);
         7'd31:  p = mk(OP_ADD, R_P01, R_T0, R_Q01);
         7'd32:  p = mk(OP_MUL, R_T0, R_A10, R_F00);
         7'd33:  p = mk(OP_MUL, R_T1, R_A11, R_F01);
         7'd34:  p = mk(OP_ADD, R_T0, R_T0, R_T1);
         7'd35:  p = mk(OP_ADD, R_P10, R_T0, R_Q10);
         7'd36:  p = mk(OP_MUL, R_T0, R_A10, R_F10);
         7'd37:  p = mk(OP_MUL, R_T1, R_A11, R_F11);
         7'd38:  p = mk(OP_ADD, R_T0, R_T0, R_T1);
         7'd39:  p = mk(OP_ADD, R_P11, R_T0, R_Q11);
         7'd40:  p = mk(OP_PRED, R_ZERO, R_ZERO, R_ZERO);
         // P H^T
         7'd41:  p = mk(OP_MUL, R_T0, R_P00, R_H0);
         7'd42:  p = mk(OP_MUL, R_T1, R_P01, R_H1);
         7'd43:  p = mk(OP_ADD, R_PH0, R_T0, R_T1);
         7'd44:  p = mk(OP_MUL, R_T0, R_P10, R_H0);
         7'd45:  p = mk(OP_MUL, R_T1, R_P11, R_H1);
         7'd46:  p = mk(OP_ADD, R_PH1, R_T0, R_T1);
         // Innovation variance and gain
         7'd47:  p = mk(OP_MUL, R_T0, R_H0, R_PH0);
         7'd48:  p = mk(OP_MUL, R_T1, R_H1, R_PH1);
         7'd49:  p = mk(OP_ADD, R_T0, R_T0, R_T1);
         7'd50:  p = mk(OP_ADD, R_S, R_T0, R_RN);
         7'd51:  p = mk(OP_DIV, R_K0, R_PH0, R_S);
         7'd52:  p = mk(OP_DIV, R_K1, R_PH1, R_S);
         // Innovation and state correction
         7'd53:  p = mk(OP_MUL, R_T0, R_H0, R_X0);
         7'd54:  p = mk(OP_MUL, R_T1, R_H1, R_X1);
         7'd55:  p = mk(OP_ADD, R_T0, R_T0, R_T1);
         7'd56:  p = mk(OP_SUB, R_INNOV, R_Z, R_T0);
         7'd57:  p = mk(OP_MUL, R_T0, R_K0, R_INNOV);
         7'd58:  p = mk(OP_ADD, R_X0, R_X0, R_T0);
         7'd59:  p = mk(OP_MUL, R_T0, R_K1, R_INNOV);
         7'd60:  p = mk(OP_ADD, R_X1, R_X1, R_T0);
         // M = I - K H
         7'd61:  p = mk(OP_MUL, R_T0, R_K0, R_H0);
         7'd62:  p = mk(OP_SUB, R_M00, R_ONE, R_T0);
         7'd63:  p = mk(OP_MUL, R_T0, R_K0, R_H1);
         7'd64:  p = mk(OP_SUB, R_M01, R_ZERO, R_T0);
         7'd65:  p = mk(OP_MUL, R_T0, R_K1, R_H0);
         7'd66:  p = mk(OP_SUB, R_M10, R_ZERO, R_T0);
         7'd67:  p = mk(OP_MUL, R_T0, R_K1, R_H1);
         7'd68:  p = mk(OP_SUB, R_M11, R_ONE, R_T0);
         7'd69:  p = mk(OP_MUL, R_KR0, R_K0, R_RN);
         7'd70:  p = mk(OP_MUL, R_KR1, R_K1, R_RN);
         // B = M P, kept in the A registers
         7'd71:  p = mk(OP_MUL, R_T0, R_M00, R_P00);
         7'd72:  p = mk(OP_MUL, R_T1, R_M01, R_P10);
         7'd73:  p = mk(OP_ADD, R_A00, R_T0, R_T1);
         7'd74:  p = mk(OP_MUL, R_T0, R_M00, R_P01);
         7'd75:  p = mk(OP_MUL, R_T1, R_M01, R_P11);
         7'd76:  p = mk(OP_ADD, R_A01, R_T0, R_T1);
         7'd77:  p = mk(OP_MUL, R_T0, R_M10, R_P00);
         7'd78:  p = mk(OP_MUL, R_T1, R_M11, R_P10);
         7'd79:  p = mk(OP_ADD, R_A10, R_T0, R_T1);
         7'd80:  p = mk(OP_MUL, R_T0, R_M10, R_P01);
         7'd81:  p = mk(OP_MUL, R_T1, R_M11, R_P11);
         7'd82:  p = mk(OP_ADD, R_A11, R_T0, R_T1);
         // P = B M^T + K R K^T
         7'd83:  p = mk(OP_MUL, R_T0, R_A00, R_M00);
         7'd84:  p = mk(OP_MUL, R_T1, R_A01, R_M01);
         7'd85:  p = mk(OP_ADD, R_T0, R_T0, R_T1);
         7'd86:  p = mk(OP_MUL, R_T1, R_KR0, R_K0);
         7'd87:  p = mk(OP_ADD, R_P00, R_T0, R_T1);
         7'd88:  p = mk(OP_MUL, R_T0, R_A00, R_M10);
         7'd89:  p = mk(OP_MUL, R_T1, R_A01, R_M11);
         7'd90:  p = mk(OP_ADD, R_T0, R_T0, R_T1);
         7'd91:  p = mk(OP_MUL, R_T1, R_KR0, R_K1);
         7'd92:  p = mk(OP_ADD, R_P01, R_T0, R_T1);
         7'd93:  p = mk(OP_MUL, R_T0, R_A10, R_M00);
         7'd94:  p = mk(OP_MUL, R_T1, R_A11, R_M01);
         7'd95:  p = mk(OP_ADD, R_T0, R_T0, R_T1);
         7'd96:  p = mk(OP_MUL, R_T1, R_KR1, R_K0);
         7'd97:  p = mk(OP_ADD, R_P10, R_T0, R_T1);
         7'd98:  p = mk(OP_MUL, R_T0, R_A10, R_M10);
         7'd99:  p = mk(OP_MUL, R_T1, R_A11, R_M11);
         7'd100: p = mk(OP_ADD, R_T0, R_T0, R_T1);
         7'd101: p = mk(OP_MUL, R_T1, R_KR1, R_K1);
         7'd102: p = mk(OP_ADD, R_P11, R_T0, R_T1);
         // Emit the result, then predict with u = a - g
         7'd103: p = mk(OP_OUT, R_ZERO, R_X0, R_X1);
         7'd104: p = mk(OP_SUB, R_U, R_ACC, R_GRAV);
         7'd105: p = mk(OP_CALL, R_ZERO, R_ZERO, R_ZERO);
         default: p = mk(OP_PRED, R_ZERO, R_ZERO, R_ZERO);
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/kalman_altitude_velocity_2state.sv
// Top level: microcoded two-state altitude/velocity filter around one shared arithmetic unit.
`default_nettype none

// Channel  | Ports                          | Payload
// ---------+--------------------------------+----------------------------------------
// request  | req_valid / req_ready          | req_data: altitude_sample, accel_sample
// response | rsp_valid / rsp_ready          | rsp_data: altitude_estimate, velocity_est.
// config   | csr_we, csr_index, csr_wdata   | one register write per enabled cycle
//
// An item is handled from acceptance to the next acceptance by the single shared unit,
// one operation after another: adds and subtracts, multiplies (four 24x24 partial
// products plus issue and rounding), and the two gain divisions, one quotient bit a
// cycle (skipped, with a zero result, when the divisor is zero). After the update the
// result is emitted and the trailing predict runs before the next item is accepted.
// The first item after reset also runs the initial predict.
// Reset is synchronous; it clears x to zero and loads P with 500 on the diagonal.
// A finished result waits in the output register; the sequencer stalls only if a
// second result is ready before the first has been taken.

module kalman_altitude_velocity_2state #(
   parameter int FRAC_BITS  = kav_pkg::FRAC_BITS_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire kav_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output kav_pkg::rsp_type  rsp_data,
   input  wire               csr_we,
   input  wire [2:0]         csr_index,
   input  wire [63:0]        csr_wdata
);

   localparam logic signed [47:0] OneQ    = 48'(64'd1 << FRAC_BITS);
   localparam logic signed [47:0] GravQ   = 48'((98 * (64'd1 << FRAC_BITS) + 5) / 10);
   localparam logic signed [47:0] InitVar = 48'(64'd500 << FRAC_BITS);
   localparam logic signed [47:0] OutMax  =
      48'((64'sd1 <<< (kav_pkg::DATA_WIDTH_DEF - 1)) - 64'sd1);
   localparam logic signed [47:0] OutMin  = -OutMax - 48'sd1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_WAIT
   } seq_state_type;

   // Configuration registers
   logic [63:0] tr0_ff;
   logic [63:0] tr1_ff;
   logic [63:0] gain_ff;
   logic [63:0] qn0_ff;
   logic [63:0] qn1_ff;
   logic [63:0] obs_ff;
   logic [30:0] rn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tr0_ff  <= '0;
         tr1_ff  <= '0;
         gain_ff <= '0;
         qn0_ff  <= '0;
         qn1_ff  <= '0;
         obs_ff  <= '0;
         rn_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            kav_pkg::CSR_TRANSITION_ROW0:    tr0_ff  <= csr_wdata;
            kav_pkg::CSR_TRANSITION_ROW1:    tr1_ff  <= csr_wdata;
            kav_pkg::CSR_CONTROL_GAIN:       gain_ff <= csr_wdata;
            kav_pkg::CSR_PROCESS_NOISE_ROW0: qn0_ff  <= csr_wdata;
            kav_pkg::CSR_PROCESS_NOISE_ROW1: qn1_ff  <= csr_wdata;
            kav_pkg::CSR_OBSERVATION_ROW:    obs_ff  <= csr_wdata;
            kav_pkg::CSR_MEASUREMENT_NOISE:  rn_ff   <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // Sequencer and scratch registers
   seq_state_type        state_ff;
   logic [6:0]           pc_ff;
   logic                 primed_ff;
   logic signed [31:0]   z_ff;
   logic signed [31:0]   acc_ff;
   logic signed [47:0]   scr_ff [kav_pkg::SCR_NUM];
   kav_pkg::alu_cmd_type cmd_ff;
   logic signed [47:0]   opa_ff;
   logic signed [47:0]   opb_ff;
   logic                 rsp_valid_ff;
   kav_pkg::rsp_type     rsp_data_ff;

   logic                 alu_done;
   logic signed [47:0]   alu_y;
   kav_pkg::instr_type   ins;

   assign ins = kav_pkg::prog(pc_ff);

   function automatic logic signed [47:0] sx32(input logic [31:0] v);
      return {{16{v[31]}}, v};
   endfunction

   function automatic logic [4:0] scr_idx(input logic [5:0] idx);
      logic [5:0] d;
      d = idx - kav_pkg::SCR_BASE;
      return d[4:0];
   endfunction

   function automatic logic signed [47:0] init_val(input int i);
      logic signed [47:0] r;
      r = '0;
      if (i == int'(kav_pkg::R_P00 - kav_pkg::SCR_BASE) ||
          i == int'(kav_pkg::R_P11 - kav_pkg::SCR_BASE)) begin
         r = InitVar;
      end
      return r;
   endfunction

   // Operand read: constants, configuration, samples, scratch
   function automatic logic signed [47:0] rd(input logic [5:0] idx);
      logic signed [47:0] r;
      case (idx)
         kav_pkg::R_ZERO: r = '0;
         kav_pkg::R_ONE:  r = OneQ;
         kav_pkg::R_GRAV: r = GravQ;
         kav_pkg::R_F00:  r = sx32(tr0_ff[63:32]);
         kav_pkg::R_F01:  r = sx32(tr0_ff[31:0]);
         kav_pkg::R_F10:  r = sx32(tr1_ff[63:32]);
         kav_pkg::R_F11:  r = sx32(tr1_ff[31:0]);
         kav_pkg::R_G0:   r = sx32(gain_ff[63:32]);
         kav_pkg::R_G1:   r = sx32(gain_ff[31:0]);
         kav_pkg::R_Q00:  r = sx32(qn0_ff[63:32]);
         kav_pkg::R_Q01:  r = sx32(qn0_ff[31:0]);
         kav_pkg::R_Q10:  r = sx32(qn1_ff[63:32]);
         kav_pkg::R_Q11:  r = sx32(qn1_ff[31:0]);
         kav_pkg::R_H0:   r = sx32(obs_ff[63:32]);
         kav_pkg::R_H1:   r = sx32(obs_ff[31:0]);
         kav_pkg::R_RN:   r = {17'd0, rn_ff};
         kav_pkg::R_Z:    r = sx32(z_ff);
         kav_pkg::R_ACC:  r = sx32(acc_ff);
         default:         r = scr_ff[scr_idx(idx)];
      endcase
      return r;
   endfunction

   // Saturate a state entry to the output range
   function automatic logic [31:0] out_sat(input logic signed [47:0] v);
      logic signed [47:0] c;
      if (v > OutMax) begin
         c = OutMax;
      end else if (v < OutMin) begin
         c = OutMin;
      end else begin
         c = v;
      end
      return c[31:0];
   endfunction

   // Microprogram sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         primed_ff    <= 1'b0;
         cmd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < kav_pkg::SCR_NUM; i++) begin
            scr_ff[i] <= init_val(i);
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  z_ff     <= req_data.altitude_sample;
                  acc_ff   <= req_data.accel_sample;
                  pc_ff    <= primed_ff ? kav_pkg::UPD_START : 7'd0;
                  state_ff <= S_ISSUE;
               end
            end
            S_ISSUE: begin
               case (ins.op)
                  kav_pkg::OP_ADD, kav_pkg::OP_SUB, kav_pkg::OP_MUL, kav_pkg::OP_DIV: begin
                     opa_ff       <= rd(ins.src_a);
                     opb_ff       <= rd(ins.src_b);
                     cmd_ff.op    <= ins.op;
                     cmd_ff.start <= 1'b1;
                     state_ff     <= S_WAIT;
                  end
                  kav_pkg::OP_OUT: begin
                     if (!rsp_valid_ff) begin
                        rsp_data_ff.altitude_estimate <= out_sat(rd(ins.src_a));
                        rsp_data_ff.velocity_estimate <= out_sat(rd(ins.src_b));
                        rsp_valid_ff <= 1'b1;
                        pc_ff        <= pc_ff + 7'd1;
                     end
                  end
                  kav_pkg::OP_CALL: pc_ff <= kav_pkg::PRED_START;
                  kav_pkg::OP_PRED: begin
                     if (!primed_ff) begin
                        primed_ff <= 1'b1;
                        pc_ff     <= kav_pkg::UPD_START;
                     end else begin
                        state_ff <= S_IDLE;
                     end
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end
            S_WAIT: begin
               cmd_ff.start <= 1'b0;
               if (alu_done) begin
                  scr_ff[scr_idx(ins.dst)] <= alu_y;
                  pc_ff    <= pc_ff + 7'd1;
                  state_ff <= S_ISSUE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   kav_alu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_ff),
      .opa   (opa_ff),
      .opb   (opb_ff),
      .done  (alu_done),
      .y     (alu_y)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/kav_alu.sv
// Shared multi-cycle arithmetic unit: saturating add/subtract, fixed-point multiply and divide.
`default_nettype none

module kav_alu #(
   parameter int FRAC_BITS = kav_pkg::FRAC_BITS_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire kav_pkg::alu_cmd_type cmd,
   input  wire logic signed [47:0]  opa,
   input  wire logic signed [47:0]  opb,
   output logic                     done,
   output logic signed [47:0]       y
);

   localparam int DivBits = 48 + FRAC_BITS;
   localparam int CntW    = $clog2(DivBits + 1);
   localparam logic [47:0] PosLim = {1'b0, {47{1'b1}}};
   localparam logic [47:0] NegLim = {1'b1, {47{1'b0}}};

   typedef enum logic [2:0] {
      A_IDLE,
      A_MUL,
      A_MFIN,
      A_DIV,
      A_DFIN
   } alu_state_type;

   alu_state_type        state_ff;
   logic                 done_ff;
   logic signed [47:0]   y_ff;
   logic                 neg_ff;
   logic [47:0]          ua_ff;
   logic [47:0]          ub_ff;
   logic [95:0]          acc_ff;
   logic [CntW-1:0]      cnt_ff;
   logic [48:0]          rem_ff;
   logic [DivBits-1:0]   quo_ff;
   logic [DivBits-1:0]   dvd_ff;

   // Saturate a 49-bit sum to 48 bits
   function automatic logic signed [47:0] sat49(input logic [48:0] v);
      logic signed [47:0] r;
      if (v[48] != v[47]) begin
         r = v[48] ? NegLim : PosLim;
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

   function automatic logic [47:0] mag(input logic signed [47:0] v);
      return v[47] ? 48'(-v) : 48'(v);
   endfunction

   // Add and subtract results
   logic [48:0] sum49;
   logic [48:0] dif49;
   assign sum49 = {opa[47], opa} + {opb[47], opb};
   assign dif49 = {opa[47], opa} - {opb[47], opb};

   // One 24x24 partial product per cycle
   logic [23:0] a_half;
   logic [23:0] b_half;
   logic [47:0] pp;
   logic [95:0] pp_sh;
   assign a_half = cnt_ff[1] ? ua_ff[47:24] : ua_ff[23:0];
   assign b_half = cnt_ff[0] ? ub_ff[47:24] : ub_ff[23:0];
   assign pp     = a_half * b_half;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    pp_sh = 96'(pp);
         2'd1:    pp_sh = 96'(pp) << 24;
         2'd2:    pp_sh = 96'(pp) << 24;
         default: pp_sh = 96'(pp) << 48;
      endcase
   end

   // Multiply rounding and saturation
   logic [47:0] lim;
   logic [95:0] rnd;
   logic [95:0] mq;
   logic [47:0] mq_sat;
   logic [48:0] mul_y;
   assign lim    = neg_ff ? NegLim : PosLim;
   assign rnd    = acc_ff + (96'(1) << (FRAC_BITS - 1));
   assign mq     = rnd >> FRAC_BITS;
   assign mq_sat = (mq > 96'(lim)) ? lim : mq[47:0];
   assign mul_y  = neg_ff ? -{1'b0, mq_sat} : {1'b0, mq_sat};

   // Restoring division step
   logic [48:0] r_sh;
   logic        r_ge;
   assign r_sh = {rem_ff[47:0], dvd_ff[DivBits-1]};
   assign r_ge = (r_sh >= {1'b0, ub_ff});

   logic [47:0] dq_sat;
   logic [48:0] div_y;
   assign dq_sat = (quo_ff > DivBits'(lim)) ? lim : quo_ff[47:0];
   assign div_y  = neg_ff ? -{1'b0, dq_sat} : {1'b0, dq_sat};

   // Sequencing of the unit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            A_IDLE: begin
               if (cmd.start) begin
                  neg_ff <= opa[47] ^ opb[47];
                  ua_ff  <= mag(opa);
                  ub_ff  <= mag(opb);
                  cnt_ff <= '0;
                  case (cmd.op)
                     kav_pkg::OP_ADD: begin
                        y_ff    <= sat49(sum49);
                        done_ff <= 1'b1;
                     end
                     kav_pkg::OP_SUB: begin
                        y_ff    <= sat49(dif49);
                        done_ff <= 1'b1;
                     end
                     kav_pkg::OP_MUL: begin
                        acc_ff   <= '0;
                        state_ff <= A_MUL;
                     end
                     kav_pkg::OP_DIV: begin
                        if (opb == '0) begin
                           y_ff    <= '0;
                           done_ff <= 1'b1;
                        end else begin
                           rem_ff   <= '0;
                           quo_ff   <= '0;
                           dvd_ff   <= DivBits'(mag(opa)) << FRAC_BITS;
                           state_ff <= A_DIV;
                        end
                     end
                     default: begin
                        y_ff    <= '0;
                        done_ff <= 1'b1;
                     end
                  endcase
               end
            end
            A_MUL: begin
               acc_ff <= acc_ff + pp_sh;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CntW'(3)) begin
                  state_ff <= A_MFIN;
               end
            end
            A_MFIN: begin
               y_ff     <= mul_y[47:0];
               done_ff  <= 1'b1;
               state_ff <= A_IDLE;
            end
            A_DIV: begin
               rem_ff <= r_ge ? (r_sh - {1'b0, ub_ff}) : r_sh;
               quo_ff <= {quo_ff[DivBits-2:0], r_ge};
               dvd_ff <= dvd_ff << 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CntW'(DivBits - 1)) begin
                  state_ff <= A_DFIN;
               end
            end
            A_DFIN: begin
               y_ff     <= div_y[47:0];
               done_ff  <= 1'b1;
               state_ff <= A_IDLE;
            end
            default: state_ff <= A_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign y    = y_ff;

endmodule

`default_nettype wire

// File: tb/tb_kalman_altitude_velocity_2state.sv
// Self-checking testbench for the two-state altitude/velocity filter.
`timescale 1ns / 1ps

module tb_kalman_altitude_velocity_2state;

   localparam int     FRAC       = 16;
   localparam longint ST_MAX     = (64'sd1 <<< 47) - 1;
   localparam longint ST_MIN     = -(64'sd1 <<< 47);
   localparam longint ONE_Q      = 64'sd1 <<< FRAC;
   localparam longint GRAVITY_Q  = (98 * ONE_Q + 5) / 10;
   localparam longint INIT_VAR   = 500 * ONE_Q;
   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam int     SETTLE     = 800;
   localparam int     WATCHDOG   = 20000;
   localparam int     HOLD_LEN   = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   kav_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   kav_pkg::rsp_type rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // Filter model state and its copy of the registers
   longint flt_f[2][2], flt_g[2], flt_q[2][2], flt_h[2], flt_r;
   longint flt_x[2], flt_p[2][2];
   bit     flt_primed;

   kav_pkg::req_type pending_q[$];
   kav_pkg::rsp_type estimate_q[$];
   int      errors = 0;
   bit      quiet = 1'b0;
   int      rsp_count = 0;
   int      hold_left = 0;
   int      stall_cycles = 0;

   kalman_altitude_velocity_2state DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint sat48(input longint v);
      if (v > ST_MAX) return ST_MAX;
      if (v < ST_MIN) return ST_MIN;
      return v;
   endfunction

   function automatic longint qadd(input longint a, input longint b);
      return sat48(a + b);
   endfunction

   // Product rounded half away from zero, saturated to the word width.
   function automatic longint qmul(input longint a, input longint b);
      logic [127:0] ua, ub, pr, lim;
      bit neg;
      neg = (a < 0) != (b < 0);
      ua = 128'(a < 0 ? -a : a);
      ub = 128'(b < 0 ? -b : b);
      pr = (ua * ub + (128'd1 << (FRAC - 1))) >> FRAC;
      lim = neg ? (128'd1 << 47) : 128'(ST_MAX);
      if (pr > lim) pr = lim;
      return neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
   endfunction

   // Quotient truncated toward zero; a zero divisor gives zero.
   function automatic longint qdiv(input longint num, input longint den);
      logic [127:0] un, ud, q, lim;
      bit neg;
      if (den == 0) return 0;
      neg = (num < 0) != (den < 0);
      un = 128'(num < 0 ? -num : num);
      ud = 128'(den < 0 ? -den : den);
      q = (un << FRAC) / ud;
      lim = neg ? (128'd1 << 47) : 128'(ST_MAX);
      if (q > lim) q = lim;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   task automatic filter_predict(input longint u);
      longint x0, x1;
      longint a[2][2];
      x0 = flt_x[0];
      x1 = flt_x[1];
      for (int i = 0; i < 2; i++)
         flt_x[i] = qadd(qadd(qmul(flt_f[i][0], x0), qmul(flt_f[i][1], x1)),
                         qmul(flt_g[i], u));
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            a[i][j] = qadd(qmul(flt_f[i][0], flt_p[0][j]), qmul(flt_f[i][1], flt_p[1][j]));
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            flt_p[i][j] = qadd(qadd(qmul(a[i][0], flt_f[j][0]),
                                    qmul(a[i][1], flt_f[j][1])), flt_q[i][j]);
   endtask

   // Correct with one sample, give the estimate, then predict ahead.
   task automatic filter_step(input kav_pkg::req_type it, output kav_pkg::rsp_type est);
      longint pht[2], k[2], m[2][2], b[2][2], s, innov;
      if (!flt_primed) begin
         filter_predict(0);
         flt_primed = 1'b1;
      end
      for (int i = 0; i < 2; i++)
         pht[i] = qadd(qmul(flt_p[i][0], flt_h[0]), qmul(flt_p[i][1], flt_h[1]));
      s = qadd(qadd(qmul(flt_h[0], pht[0]), qmul(flt_h[1], pht[1])), flt_r);
      for (int i = 0; i < 2; i++) k[i] = qdiv(pht[i], s);
      innov = qadd(longint'(it.altitude_sample),
                   -qadd(qmul(flt_h[0], flt_x[0]), qmul(flt_h[1], flt_x[1])));
      for (int i = 0; i < 2; i++) flt_x[i] = qadd(flt_x[i], qmul(k[i], innov));
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            m[i][j] = qadd(i == j ? ONE_Q : 0, -qmul(k[i], flt_h[j]));
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            b[i][j] = qadd(qmul(m[i][0], flt_p[0][j]), qmul(m[i][1], flt_p[1][j]));
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            flt_p[i][j] = qadd(qadd(qmul(b[i][0], m[j][0]), qmul(b[i][1], m[j][1])),
                               qmul(qmul(k[i], flt_r), k[j]));
      est.altitude_estimate = clip32(flt_x[0]);
      est.velocity_estimate = clip32(flt_x[1]);
      filter_predict(qadd(longint'(it.accel_sample), -GRAVITY_Q));
   endtask

   // Driver: offers pending items, idling now and then, and predicts on acceptance.
   always @(posedge clock) begin
      kav_pkg::req_type it;
      kav_pkg::rsp_type est;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            filter_step(req_data, est);
            estimate_q.push_back(est);
         end
         if (!req_valid || req_ready) begin
            if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 10)) begin
               it = pending_q.pop_front();
               req_data  <= it;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result and drives the receiver's stalls.
   always @(posedge clock) begin
      kav_pkg::rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (estimate_q.size() == 0) begin
               $error("result item with no estimate waiting");
               errors++;
            end else begin
               e = estimate_q.pop_front();
               if (rsp_data.altitude_estimate !== e.altitude_estimate) begin
                  $error("altitude_estimate: expected %0d, actual %0d",
                         e.altitude_estimate, rsp_data.altitude_estimate);
                  errors++;
               end
               if (rsp_data.velocity_estimate !== e.velocity_estimate) begin
                  $error("velocity_estimate: expected %0d, actual %0d",
                         e.velocity_estimate, rsp_data.velocity_estimate);
                  errors++;
               end
            end
         end
         // One long hold-off so that the input backs up.
         if (rsp_count == 40 && rsp_valid && rsp_ready) hold_left <= HOLD_LEN;
         else if (hold_left > 0) hold_left <= hold_left - 1;
         if (hold_left > 1) rsp_ready <= 1'b0;
         else rsp_ready <= quiet || ($urandom_range(99) >= 10);
      end
   end

   // Watchdog on cycles without any accepted item.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      longint hi, lo;
      hi = longint'($signed(val[63:32]));
      lo = longint'($signed(val[31:0]));
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         kav_pkg::CSR_TRANSITION_ROW0:    begin flt_f[0][0] = hi; flt_f[0][1] = lo; end
         kav_pkg::CSR_TRANSITION_ROW1:    begin flt_f[1][0] = hi; flt_f[1][1] = lo; end
         kav_pkg::CSR_CONTROL_GAIN:       begin flt_g[0] = hi; flt_g[1] = lo; end
         kav_pkg::CSR_PROCESS_NOISE_ROW0: begin flt_q[0][0] = hi; flt_q[0][1] = lo; end
         kav_pkg::CSR_PROCESS_NOISE_ROW1: begin flt_q[1][0] = hi; flt_q[1][1] = lo; end
         kav_pkg::CSR_OBSERVATION_ROW:    begin flt_h[0] = hi; flt_h[1] = lo; end
         kav_pkg::CSR_MEASUREMENT_NOISE:  flt_r = longint'(val[30:0]);
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_item(input logic [31:0] z, input logic [31:0] a);
      kav_pkg::req_type it;
      it.altitude_sample = z;
      it.accel_sample    = a;
      pending_q.push_back(it);
   endtask

   // Waits until every item is through and the trailing predict has finished.
   task automatic drain();
      while (pending_q.size() > 0 || req_valid || estimate_q.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_config(input bit wild);
      logic [63:0] v;
      for (int r = 0; r <= int'(kav_pkg::CSR_MEASUREMENT_NOISE); r++) begin
         if (wild) v = {$urandom, $urandom};
         else v = {32'($signed($urandom_range(131072)) - 65536),
                   32'($signed($urandom_range(131072)) - 65536)};
         csr_write(3'(r), v);
      end
   endtask

   initial begin
      longint alt, vel, acc;
      for (int i = 0; i < 2; i++) begin
         flt_g[i] = 0; flt_h[i] = 0; flt_x[i] = 0;
         for (int j = 0; j < 2; j++) begin
            flt_f[i][j] = 0; flt_q[i][j] = 0;
            flt_p[i][j] = (i == j) ? INIT_VAR : 0;
         end
      end
      flt_r = 0;
      flt_primed = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // All registers zero: the innovation variance is zero, so no correction.
      push_item(32'h7FFFFFFF, 32'h80000000);
      push_item(32'h80000000, 32'h7FFFFFFF);
      push_item(32'h0, 32'h0);
      push_item(32'hFFFFFFFF, 32'hFFFFFFFF);
      drain();

      // Constant-velocity tracking with 10 ms steps, position observed.
      csr_write(kav_pkg::CSR_TRANSITION_ROW0, {32'sd65536, 32'sd655});
      csr_write(kav_pkg::CSR_TRANSITION_ROW1, {32'sd0, 32'sd65536});
      csr_write(kav_pkg::CSR_CONTROL_GAIN, {32'sd3, 32'sd655});
      csr_write(kav_pkg::CSR_PROCESS_NOISE_ROW0, {32'sd7, 32'sd0});
      csr_write(kav_pkg::CSR_PROCESS_NOISE_ROW1, {32'sd0, 32'sd655});
      csr_write(kav_pkg::CSR_OBSERVATION_ROW, {32'sd65536, 32'sd0});
      csr_write(kav_pkg::CSR_MEASUREMENT_NOISE, 64'd262144);
      csr_write(CSR_UNUSED, '1);
      push_item(32'h7FFFFFFF, 32'h0);
      push_item(32'h80000000, 32'h0);
      push_item(32'h0, 32'h7FFFFFFF);
      push_item(32'h0, 32'h80000000);
      push_item(32'h0, 32'(GRAVITY_Q));
      push_item(32'h00010000, 32'h00010000);
      alt = 0;
      vel = 0;
      quiet = 1'b1;
      for (int n = 0; n < 620; n++) begin
         if ($urandom_range(99) < 8) begin
            push_item($urandom, $urandom);
         end else begin
            acc = GRAVITY_Q + longint'($urandom_range(262144)) - 131072;
            vel = vel + (((acc - GRAVITY_Q) * 655) >>> 16);
            alt = alt + ((vel * 655) >>> 16);
            push_item(clip32(alt + longint'($urandom_range(262144)) - 131072),
                      clip32(acc));
         end
      end
      // No random idling on either side for the first stretch of this run, apart from the long hold-off.
      wait (rsp_count >= 160);
      quiet = 1'b0;
      drain();

      // Register extremes with full-range samples.
      for (int r = 0; r <= int'(kav_pkg::CSR_OBSERVATION_ROW); r++)
         csr_write(3'(r), 64'h7FFFFFFF_7FFFFFFF);
      csr_write(kav_pkg::CSR_MEASUREMENT_NOISE, 64'h7FFFFFFF);
      for (int n = 0; n < 100; n++) push_item($urandom, $urandom);
      drain();
      for (int r = 0; r <= int'(kav_pkg::CSR_OBSERVATION_ROW); r++)
         csr_write(3'(r), 64'h80000000_80000000);
      csr_write(kav_pkg::CSR_MEASUREMENT_NOISE, 64'h0);
      for (int n = 0; n < 100; n++) push_item($urandom, $urandom);
      drain();

      // Random settings, moderate in half the runs and across the whole range in the other half.
      for (int ph = 0; ph < 4; ph++) begin
         random_config(ph[0]);
         for (int n = 0; n < 150; n++) push_item($urandom, $urandom);
         drain();
      end

      if (errors == 0 && estimate_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/kav_pkg.sv
rtl/core/kav_alu.sv
rtl/core/kalman_altitude_velocity_2state.sv
tb/tb_kalman_altitude_velocity_2state.sv
